@@ hw/rtl/multi_slot_tick_timer_scheduler_macros.svh @@
// Assertion helpers for the timer scheduler checker.
`ifndef MULTI_SLOT_TICK_TIMER_SCHEDULER_MACROS_SVH
`define MULTI_SLOT_TICK_TIMER_SCHEDULER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/mstts_pkg.sv @@
package mstts_pkg;

    localparam int TimedSlots = 16;
    localparam int AsapSlots  = 8;
    localparam int AlapSlots  = 4;
    localparam int TagBits    = 8;
    localparam int TimedIdxW  = $clog2(TimedSlots);
    localparam int AsapIdxW   = $clog2(AsapSlots);
    localparam int AlapIdxW   = $clog2(AlapSlots);
    localparam logic [30:0] TickMax = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        OP_ARM_TIMED = 3'd0, OP_ARM_ASAP = 3'd1, OP_ARM_ALAP = 3'd2,
        OP_CANCEL_HANDLE = 3'd3, OP_CANCEL_NAME = 3'd4, OP_TICK = 3'd5,
        OP_ZERO = 3'd6, OP_NONE = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        K_ARM_ACK = 3'd0, K_CANCEL_ACK = 3'd1, K_ASAP_FIRE = 3'd2,
        K_TIMED_FIRE = 3'd3, K_ALAP_FIRE = 3'd4, K_TICK_DONE = 3'd5,
        K_ZERO_DONE = 3'd6, K_RSVD = 3'd7
    } t_kind;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;       // capture the input beat
        logic div_step;   // one reciprocal divide step
        logic do_single;  // perform arm / cancel / zero update
        logic scan_step;  // process one scan entry
        logic scan_clr;   // reset scan index
        logic emit_ack;   // load output with single result
        logic emit_done;  // load output with tick done
    } t_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic div_done;
        logic scan_fire;  // current scan entry produces a fire
        logic scan_end;   // current scan entry is the final one
    } t_stat;

endpackage

@@ hw/rtl/mstts_ctrl.sv @@
module mstts_ctrl
    import mstts_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_opcode i_op,
    input  logic   i_out_busy,
    input  t_stat  i_stat,
    output logic   o_stall,
    output t_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_DIV = 5'b00010, S_SINGLE = 5'b00100,
        S_SCAN = 5'b01000, S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    assign o_stall = (r_state != S_IDLE);

    // Sequencing: arm timed divides first, a tick scans all slots.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    if (i_op == OP_ARM_TIMED) n_state = S_DIV;
                    else if (i_op == OP_TICK) n_state = S_SCAN;
                    else if (i_op == OP_NONE) n_state = S_IDLE;
                    else n_state = S_SINGLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) n_state = S_SINGLE;
            end
            S_SINGLE: begin
                if (!i_out_busy) begin
                    o_cmd.do_single = 1'b1;
                    o_cmd.emit_ack = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!(i_stat.scan_fire && i_out_busy)) begin
                    o_cmd.scan_step = 1'b1;
                    if (i_stat.scan_end) n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_out_busy) begin
                    o_cmd.emit_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/mstts_dp.sv @@
module mstts_dp
    import mstts_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  t_opcode       i_opcode,
    input  logic [63:0]   i_delay_ns,
    input  logic          i_recurring,
    input  logic [7:0]    i_name_tag,
    input  logic [31:0]   i_cancel_handle,
    input  logic [31:0]   i_now_count,
    input  logic          i_out_stall,
    output t_stat         o_stat,
    output logic          o_out_busy,
    output logic          o_valid,
    output t_kind         o_kind,
    output logic [31:0]   o_slot_handle,
    output logic          o_ok,
    output logic [4:0]    o_cancel_count,
    output logic [31:0]   o_fire_count,
    output logic          o_last
);

    localparam int ScanLen = AsapSlots + TimedSlots + AlapSlots;
    localparam int ScanW   = $clog2(ScanLen + 1);
    // Scaled reciprocal of 100 / 64, rounded down: floor(2^32 * 0.64).
    localparam logic [31:0] RecipC = 32'd2748779069;

    // Captured input beat.
    t_opcode r_op;
    logic [37:0] r_ns_lo;
    logic r_big;
    logic [63:0] r_prod;
    logic [31:0] r_quo;
    logic r_div_cnt;
    logic r_rec;
    logic [TagBits-1:0] r_tag;
    logic [31:0] r_ch, r_now;

    // Slot state.
    logic [TimedSlots-1:0] r_t_act, r_t_pend, r_t_rep;
    logic [TimedSlots-1:0] n_t_act, n_t_pend, n_t_rep;
    logic [30:0] r_t_delay [TimedSlots];
    logic [31:0] r_t_dl [TimedSlots];
    logic [30:0] r_t_per [TimedSlots];
    logic [31:0] r_t_id [TimedSlots];
    logic [TagBits-1:0] r_t_tag [TimedSlots];
    logic [AsapSlots-1:0] r_s_act, n_s_act;
    logic [31:0] r_s_id [AsapSlots];
    logic [TagBits-1:0] r_s_tag [AsapSlots];
    logic [AlapSlots-1:0] r_l_act, n_l_act;
    logic [31:0] r_l_id [AlapSlots];
    logic [TagBits-1:0] r_l_tag [AlapSlots];
    logic [31:0] r_next_id, n_next_id;
    logic [ScanW-1:0] r_scan, n_scan;

    // Output register.
    logic r_ov, n_ov;
    t_kind r_kind, n_kind;
    logic [31:0] r_h, r_fc, n_h, n_fc;
    logic r_ok, r_last, n_ok, n_last;
    logic [4:0] r_cnt, n_cnt;

    assign o_valid = r_ov;
    assign o_kind = r_kind;
    assign o_slot_handle = r_h;
    assign o_ok = r_ok;
    assign o_cancel_count = r_cnt;
    assign o_fire_count = r_fc;
    assign o_last = r_last;
    assign o_out_busy = r_ov && i_out_stall;

    // Divide by 100 in two steps: a reciprocal estimate of ns / 64 * 0.64,
    // then one remainder check that adds the missing 0, 1 or 2.
    // Delays of 2^38 ns and above always clamp, so only 38 bits are divided.
    logic [31:0] w_q0;
    logic [38:0] w_back;
    logic [38:0] w_rdiff;
    logic [8:0] w_r;
    logic [31:0] w_quo_fix;
    always_comb begin
        w_q0 = r_prod[63:32];
        w_back = 39'(w_q0) * 39'd100;
        w_rdiff = 39'(r_ns_lo) - w_back;
        w_r = w_rdiff[8:0];
        if (w_r >= 9'd200) w_quo_fix = w_q0 + 32'd2;
        else if (w_r >= 9'd100) w_quo_fix = w_q0 + 32'd1;
        else w_quo_fix = w_q0;
    end
    assign o_stat.div_done = r_div_cnt;

    // Clamp of quotient to tick range.
    logic [30:0] w_ticks;
    always_comb begin
        if (r_big || r_quo[31]) w_ticks = TickMax;
        else if (r_quo[30:0] == '0) w_ticks = 31'd1;
        else w_ticks = r_quo[30:0];
    end

    // Retire-by-tag match vectors and count.
    logic [TimedSlots-1:0] w_t_tm, w_t_hm;
    logic [AsapSlots-1:0] w_s_tm, w_s_hm;
    logic [AlapSlots-1:0] w_l_tm, w_l_hm;
    logic [4:0] w_tag_cnt;
    always_comb begin
        for (int i = 0; i < TimedSlots; i++) begin
            w_t_tm[i] = r_t_act[i] && (r_tag != '0) && (r_t_tag[i] == r_tag);
            w_t_hm[i] = r_t_act[i] && (r_ch != '0) && (r_t_id[i] == r_ch);
        end
        for (int i = 0; i < AsapSlots; i++) begin
            w_s_tm[i] = r_s_act[i] && (r_tag != '0) && (r_s_tag[i] == r_tag);
            w_s_hm[i] = r_s_act[i] && (r_ch != '0) && (r_s_id[i] == r_ch);
        end
        for (int i = 0; i < AlapSlots; i++) begin
            w_l_tm[i] = r_l_act[i] && (r_tag != '0) && (r_l_tag[i] == r_tag);
            w_l_hm[i] = r_l_act[i] && (r_ch != '0) && (r_l_id[i] == r_ch);
        end
        w_tag_cnt = 5'($countones(w_t_tm)) + 5'($countones(w_s_tm))
                  + 5'($countones(w_l_tm));
    end

    // First free slot after retirement.
    logic [TimedSlots-1:0] w_t_free;
    logic [AsapSlots-1:0] w_s_free;
    logic [AlapSlots-1:0] w_l_free;
    logic w_t_any, w_s_any, w_l_any;
    logic [TimedIdxW-1:0] w_t_fi;
    logic [AsapIdxW-1:0] w_s_fi;
    logic [AlapIdxW-1:0] w_l_fi;
    always_comb begin
        w_t_free = ~(r_t_act & ~w_t_tm);
        w_s_free = ~(r_s_act & ~w_s_tm);
        w_l_free = ~(r_l_act & ~w_l_tm);
        w_t_any = |w_t_free;
        w_s_any = |w_s_free;
        w_l_any = |w_l_free;
        w_t_fi = '0;
        w_s_fi = '0;
        w_l_fi = '0;
        for (int i = TimedSlots - 1; i >= 0; i--)
            if (w_t_free[i]) w_t_fi = TimedIdxW'(i);
        for (int i = AsapSlots - 1; i >= 0; i--)
            if (w_s_free[i]) w_s_fi = AsapIdxW'(i);
        for (int i = AlapSlots - 1; i >= 0; i--)
            if (w_l_free[i]) w_l_fi = AlapIdxW'(i);
    end

    logic [31:0] w_id_inc;
    assign w_id_inc = (r_next_id == 32'hFFFF_FFFF) ? 32'd1 : r_next_id + 32'd1;

    // Scan entry decode: ASAP, then timed, then ALAP.
    logic w_in_s, w_in_t, w_in_l;
    logic [AsapIdxW-1:0] w_si;
    logic [TimedIdxW-1:0] w_ti;
    logic [AlapIdxW-1:0] w_li;
    logic [31:0] w_dl, w_adv, w_rebase;
    logic w_exp, w_fire, w_rep_ok;
    always_comb begin
        w_in_s = (r_scan < ScanW'(AsapSlots));
        w_in_t = !w_in_s && (r_scan < ScanW'(AsapSlots + TimedSlots));
        w_in_l = !w_in_s && !w_in_t;
        w_si = AsapIdxW'(r_scan);
        w_ti = TimedIdxW'(r_scan - ScanW'(AsapSlots));
        w_li = AlapIdxW'(r_scan - ScanW'(AsapSlots + TimedSlots));
        // A pending slot anchors and is then tested in the same step.
        w_dl = r_t_pend[w_ti] ? (r_now + {1'b0, r_t_delay[w_ti]}) : r_t_dl[w_ti];
        w_exp = !(r_now - w_dl >= 32'h8000_0000);
        w_rep_ok = r_t_rep[w_ti] && (r_t_per[w_ti] != '0);
        w_adv = w_dl + {1'b0, r_t_per[w_ti]};
        w_rebase = r_now + {1'b0, r_t_per[w_ti]};
        if (w_in_s) w_fire = r_s_act[w_si];
        else if (w_in_t) w_fire = r_t_act[w_ti] && w_exp;
        else w_fire = r_l_act[w_li];
    end
    assign o_stat.scan_fire = w_fire;
    assign o_stat.scan_end = (r_scan == ScanW'(ScanLen - 1));

    // Payload registers of the slot tables and capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_ns_lo <= i_delay_ns[37:0];
            r_big <= (i_delay_ns[63:38] != '0);
            r_rec <= i_recurring;
            r_tag <= i_name_tag[TagBits-1:0];
            r_ch  <= i_cancel_handle;
            r_now <= i_now_count;
            r_div_cnt <= 1'b0;
        end
        if (i_cmd.div_step) begin
            // First step forms the estimate, second step corrects it.
            r_div_cnt <= 1'b1;
            if (!r_div_cnt) r_prod <= r_ns_lo[37:6] * RecipC;
            else r_quo <= w_quo_fix;
        end
        if (i_cmd.do_single && r_op == OP_ARM_TIMED && w_t_any) begin
            r_t_delay[w_t_fi] <= w_ticks;
            r_t_dl[w_t_fi]    <= '0;
            r_t_per[w_t_fi]   <= r_rec ? w_ticks : 31'd0;
            r_t_id[w_t_fi]    <= r_next_id;
            r_t_tag[w_t_fi]   <= r_tag;
        end
        if (i_cmd.do_single && r_op == OP_ARM_ASAP && w_s_any) begin
            r_s_id[w_s_fi]  <= r_next_id;
            r_s_tag[w_s_fi] <= r_tag;
        end
        if (i_cmd.do_single && r_op == OP_ARM_ALAP && w_l_any) begin
            r_l_id[w_l_fi]  <= r_next_id;
            r_l_tag[w_l_fi] <= r_tag;
        end
        if (i_cmd.do_single && r_op == OP_ZERO) begin
            for (int i = 0; i < TimedSlots; i++)
                if (r_t_act[i] && r_t_rep[i] && r_t_per[i] != '0)
                    r_t_delay[i] <= r_t_per[i];
        end
        if (i_cmd.scan_step && w_in_t && r_t_act[w_ti]) begin
            if (w_exp && w_rep_ok) begin
                if (!(r_now - w_adv >= 32'h8000_0000)) r_t_dl[w_ti] <= w_rebase;
                else r_t_dl[w_ti] <= w_adv;
            end else begin
                r_t_dl[w_ti] <= w_dl;
            end
        end
    end

    // Next values of the table flags, handle counter, scan index and output.
    always_comb begin
        n_t_act = r_t_act;
        n_t_pend = r_t_pend;
        n_t_rep = r_t_rep;
        n_s_act = r_s_act;
        n_l_act = r_l_act;
        n_next_id = r_next_id;
        n_scan = r_scan;
        n_ov = r_ov;
        n_kind = r_kind;
        n_h = r_h;
        n_fc = r_fc;
        n_ok = r_ok;
        n_cnt = r_cnt;
        n_last = r_last;
        if (r_ov && !i_out_stall) n_ov = 1'b0;
        if (i_cmd.scan_clr) n_scan = '0;
        if (i_cmd.do_single) begin
            n_ov = 1'b1;
            n_fc = '0;
            n_last = 1'b1;
            n_cnt = '0;
            unique case (r_op)
                OP_ARM_TIMED, OP_ARM_ASAP, OP_ARM_ALAP: begin
                    n_t_act = r_t_act & ~w_t_tm;
                    n_s_act = r_s_act & ~w_s_tm;
                    n_l_act = r_l_act & ~w_l_tm;
                    n_kind = K_ARM_ACK;
                    n_h = '0;
                    n_ok = 1'b0;
                    if (r_op == OP_ARM_TIMED && w_t_any) begin
                        n_t_act[w_t_fi] = 1'b1;
                        n_t_pend[w_t_fi] = 1'b1;
                        n_t_rep[w_t_fi] = r_rec;
                        n_h = r_next_id;
                        n_ok = 1'b1;
                        n_next_id = w_id_inc;
                    end else if (r_op == OP_ARM_ASAP && w_s_any) begin
                        n_s_act[w_s_fi] = 1'b1;
                        n_h = r_next_id;
                        n_ok = 1'b1;
                        n_next_id = w_id_inc;
                    end else if (r_op == OP_ARM_ALAP && w_l_any) begin
                        n_l_act[w_l_fi] = 1'b1;
                        n_h = r_next_id;
                        n_ok = 1'b1;
                        n_next_id = w_id_inc;
                    end
                end
                OP_CANCEL_HANDLE: begin
                    n_t_act = r_t_act & ~w_t_hm;
                    n_s_act = r_s_act & ~w_s_hm;
                    n_l_act = r_l_act & ~w_l_hm;
                    n_kind = K_CANCEL_ACK;
                    n_h = r_ch;
                    n_ok = (|w_t_hm) || (|w_s_hm) || (|w_l_hm);
                end
                OP_CANCEL_NAME: begin
                    n_t_act = r_t_act & ~w_t_tm;
                    n_s_act = r_s_act & ~w_s_tm;
                    n_l_act = r_l_act & ~w_l_tm;
                    n_kind = K_CANCEL_ACK;
                    n_h = '0;
                    n_ok = (w_tag_cnt != '0);
                    n_cnt = w_tag_cnt;
                end
                default: begin
                    n_t_pend = r_t_pend | r_t_act;
                    n_kind = K_ZERO_DONE;
                    n_h = '0;
                    n_ok = 1'b0;
                end
            endcase
        end
        if (i_cmd.scan_step) begin
            n_scan = r_scan + ScanW'(1);
            if (w_in_s) begin
                n_s_act[w_si] = 1'b0;
            end else if (w_in_t) begin
                if (r_t_act[w_ti]) n_t_pend[w_ti] = 1'b0;
                if (w_fire && !w_rep_ok) n_t_act[w_ti] = 1'b0;
            end else begin
                n_l_act[w_li] = 1'b0;
            end
            if (w_fire) begin
                n_ov = 1'b1;
                n_kind = w_in_s ? K_ASAP_FIRE : (w_in_t ? K_TIMED_FIRE : K_ALAP_FIRE);
                n_h = w_in_s ? r_s_id[w_si] : (w_in_t ? r_t_id[w_ti] : r_l_id[w_li]);
                n_fc = w_in_t ? r_now : 32'd0;
                n_ok = 1'b0;
                n_cnt = '0;
                n_last = 1'b0;
            end
        end
        if (i_cmd.emit_done) begin
            n_ov = 1'b1;
            n_kind = K_TICK_DONE;
            n_h = '0;
            n_fc = '0;
            n_ok = 1'b0;
            n_cnt = '0;
            n_last = 1'b1;
        end
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_act <= '0;
            r_t_pend <= '0;
            r_t_rep <= '0;
            r_s_act <= '0;
            r_l_act <= '0;
            r_next_id <= 32'd1;
            r_scan <= '0;
            r_ov <= 1'b0;
        end else begin
            r_t_act <= n_t_act;
            r_t_pend <= n_t_pend;
            r_t_rep <= n_t_rep;
            r_s_act <= n_s_act;
            r_l_act <= n_l_act;
            r_next_id <= n_next_id;
            r_scan <= n_scan;
            r_ov <= n_ov;
            r_kind <= n_kind;
            r_h <= n_h;
            r_fc <= n_fc;
            r_ok <= n_ok;
            r_cnt <= n_cnt;
            r_last <= n_last;
        end
    end

endmodule

@@ hw/rtl/multi_slot_tick_timer_scheduler.sv @@
// Arm timed: the beat is captured, a two-step divide by 100 runs, then the slot update loads the result.
// Other arm, cancel and counter-zero beats: the beat is captured, then the update loads the result.
// Tick: one cycle per ASAP, timed and ALAP slot while no fire waits on a busy output, then a done beat.
// One input beat is worked at a time; a result waits in the output register while the receiver stalls.
// Synchronous active-low reset clears all slot valid bits and sets the next handle to 1.
module multi_slot_tick_timer_scheduler
    import mstts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_delay_ns,
    input  logic        i_recurring,
    input  logic [7:0]  i_name_tag,
    input  logic [31:0] i_cancel_handle,
    input  logic [31:0] i_now_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [31:0] o_slot_handle,
    output logic        o_ok,
    output logic [4:0]  o_cancel_count,
    output logic [31:0] o_fire_count,
    output logic        o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_out_busy;
    t_kind w_kind;

    assign o_kind = w_kind;

    // Sequencer.
    mstts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_op(t_opcode'(i_opcode)), .i_out_busy(w_out_busy), .i_stat(w_stat),
        .o_stall(o_stall), .o_cmd(w_cmd)
    );

    // Slot tables and output register.
    mstts_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_opcode(t_opcode'(i_opcode)), .i_delay_ns(i_delay_ns),
        .i_recurring(i_recurring), .i_name_tag(i_name_tag),
        .i_cancel_handle(i_cancel_handle), .i_now_count(i_now_count),
        .i_out_stall(i_stall), .o_stat(w_stat), .o_out_busy(w_out_busy),
        .o_valid(o_valid), .o_kind(w_kind), .o_slot_handle(o_slot_handle),
        .o_ok(o_ok), .o_cancel_count(o_cancel_count),
        .o_fire_count(o_fire_count), .o_last(o_last)
    );

endmodule

@@ hw/rtl/mstts_checker.sv @@
`include "multi_slot_tick_timer_scheduler_macros.svh"
module mstts_checker
    import mstts_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_kind,
    input logic [31:0] o_slot_handle,
    input logic        o_ok,
    input logic [31:0] o_fire_count,
    input logic        o_last
);

    logic w_is_fire;
    assign w_is_fire = (o_kind == K_ASAP_FIRE) || (o_kind == K_TIMED_FIRE)
                    || (o_kind == K_ALAP_FIRE);

    // A stalled result beat holds.
    `MST_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_slot_handle))
    // Fires are never the closing beat; acks always are, though only fires are checked here.
    `MST_ASSERT_IMP(a_fire_last, i_clk, i_rst_n, o_valid && w_is_fire, !o_last)
    // A successful arm never returns handle zero.
    `MST_ASSERT_IMP(a_arm_h, i_clk, i_rst_n, o_valid && o_kind == K_ARM_ACK && o_ok, o_slot_handle != 0)
    // Only timed fires carry a fire count.
    `MST_ASSERT_IMP(a_fc, i_clk, i_rst_n, o_valid && o_kind != K_TIMED_FIRE, o_fire_count == 32'd0)

endmodule

bind multi_slot_tick_timer_scheduler mstts_checker u_chk (.*);

@@ tb/sv/multi_slot_tick_timer_scheduler_checker.sv @@
`timescale 1ns / 1ps
module multi_slot_tick_timer_scheduler_checker
    import mstts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_delay_ns,
    input  logic        i_recurring,
    input  logic [7:0]  i_name_tag,
    input  logic [31:0] i_cancel_handle,
    input  logic [31:0] i_now_count,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_slot_handle,
    input  logic        i_ok,
    input  logic [4:0]  i_cancel_count,
    input  logic [31:0] i_fire_count,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending,
    output int          o_fires
);

    typedef struct packed {
        t_kind       kind;
        logic [31:0] handle;
        logic        ok;
        logic [4:0]  count;
        logic [31:0] fire_at;
        logic        last;
    } t_result;

    // Scheduler state mirrored from the block's behavior.
    logic        tm_act [TimedSlots];
    logic        tm_anchor [TimedSlots];
    logic        tm_rep [TimedSlots];
    logic [31:0] tm_delay [TimedSlots];
    logic [31:0] tm_dl [TimedSlots];
    logic [31:0] tm_per [TimedSlots];
    logic [31:0] tm_id [TimedSlots];
    logic [7:0]  tm_tag [TimedSlots];
    logic        as_act [AsapSlots];
    logic [31:0] as_id [AsapSlots];
    logic [7:0]  as_tag [AsapSlots];
    logic        al_act [AlapSlots];
    logic [31:0] al_id [AlapSlots];
    logic [7:0]  al_tag [AlapSlots];
    logic [31:0] handle_next;

    t_result results_due[$];

    function automatic t_result mk(t_kind k, logic [31:0] h, logic ok, logic [4:0] c,
                                   logic [31:0] f, logic l);
        t_result r;
        r.kind = k; r.handle = h; r.ok = ok; r.count = c; r.fire_at = f; r.last = l;
        return r;
    endfunction

    function automatic logic [31:0] grab_handle();
        logic [31:0] h;
        h = handle_next;
        handle_next = handle_next + 1;
        if (handle_next == 0) handle_next = 1;
        return h;
    endfunction

    function automatic logic late(logic [31:0] dl, logic [31:0] now);
        logic [31:0] d;
        d = now - dl;
        return !d[31];
    endfunction

    function automatic int retire_named(logic [7:0] tag);
        int n;
        n = 0;
        if (tag == 0) return 0;
        for (int i = 0; i < TimedSlots; i++)
            if (tm_act[i] && tm_tag[i] == tag) begin tm_act[i] = 0; n++; end
        for (int i = 0; i < AsapSlots; i++)
            if (as_act[i] && as_tag[i] == tag) begin as_act[i] = 0; n++; end
        for (int i = 0; i < AlapSlots; i++)
            if (al_act[i] && al_tag[i] == tag) begin al_act[i] = 0; n++; end
        return n;
    endfunction

    // Works out the results of one accepted beat and updates the mirror.
    task automatic schedule_beat(t_opcode op, logic [63:0] ns, logic rec, logic [7:0] tag,
                                 logic [31:0] ch, logic [31:0] now);
        logic [63:0] t;
        logic [31:0] h;
        logic found;
        int n;
        h = 0;
        found = 0;
        case (op)
            OP_ARM_TIMED, OP_ARM_ASAP, OP_ARM_ALAP: begin
                n = retire_named(tag);
                if (op == OP_ARM_TIMED) begin
                    t = ns / 100;
                    if (t < 1) t = 1;
                    if (t > 64'h7FFF_FFFF) t = 64'h7FFF_FFFF;
                    for (int i = 0; i < TimedSlots; i++) if (!tm_act[i] && h == 0) begin
                        h = grab_handle();
                        tm_act[i] = 1; tm_anchor[i] = 1; tm_rep[i] = rec;
                        tm_delay[i] = t[31:0]; tm_dl[i] = 0;
                        tm_per[i] = rec ? t[31:0] : 32'd0;
                        tm_id[i] = h; tm_tag[i] = tag;
                    end
                end else if (op == OP_ARM_ASAP) begin
                    for (int i = 0; i < AsapSlots; i++) if (!as_act[i] && h == 0) begin
                        h = grab_handle();
                        as_act[i] = 1; as_id[i] = h; as_tag[i] = tag;
                    end
                end else begin
                    for (int i = 0; i < AlapSlots; i++) if (!al_act[i] && h == 0) begin
                        h = grab_handle();
                        al_act[i] = 1; al_id[i] = h; al_tag[i] = tag;
                    end
                end
                results_due.push_back(mk(K_ARM_ACK, h, h != 0, 0, 0, 1));
            end
            OP_CANCEL_HANDLE: begin
                if (ch != 0) begin
                    for (int i = 0; i < TimedSlots; i++)
                        if (tm_act[i] && tm_id[i] == ch) begin tm_act[i] = 0; found = 1; end
                    for (int i = 0; i < AsapSlots; i++)
                        if (as_act[i] && as_id[i] == ch) begin as_act[i] = 0; found = 1; end
                    for (int i = 0; i < AlapSlots; i++)
                        if (al_act[i] && al_id[i] == ch) begin al_act[i] = 0; found = 1; end
                end
                results_due.push_back(mk(K_CANCEL_ACK, ch, found, 0, 0, 1));
            end
            OP_CANCEL_NAME: begin
                n = retire_named(tag);
                results_due.push_back(mk(K_CANCEL_ACK, 0, n != 0, n[4:0], 0, 1));
            end
            OP_TICK: begin
                for (int i = 0; i < AsapSlots; i++) if (as_act[i]) begin
                    results_due.push_back(mk(K_ASAP_FIRE, as_id[i], 0, 0, 0, 0));
                    as_act[i] = 0;
                end
                for (int i = 0; i < TimedSlots; i++) if (tm_act[i] && tm_anchor[i]) begin
                    tm_dl[i] = now + tm_delay[i];
                    tm_anchor[i] = 0;
                end
                for (int i = 0; i < TimedSlots; i++) begin
                    if (tm_act[i] && !tm_anchor[i] && late(tm_dl[i], now)) begin
                        results_due.push_back(mk(K_TIMED_FIRE, tm_id[i], 0, 0, now, 0));
                        if (tm_rep[i] && tm_per[i] > 0) begin
                            tm_dl[i] = tm_dl[i] + tm_per[i];
                            if (late(tm_dl[i], now)) tm_dl[i] = now + tm_per[i];
                        end else begin
                            tm_act[i] = 0;
                        end
                    end
                end
                for (int i = 0; i < AlapSlots; i++) if (al_act[i]) begin
                    results_due.push_back(mk(K_ALAP_FIRE, al_id[i], 0, 0, 0, 0));
                    al_act[i] = 0;
                end
                results_due.push_back(mk(K_TICK_DONE, 0, 0, 0, 0, 1));
            end
            OP_ZERO: begin
                for (int i = 0; i < TimedSlots; i++) if (tm_act[i]) begin
                    tm_anchor[i] = 1;
                    if (tm_rep[i] && tm_per[i] > 0) tm_delay[i] = tm_per[i];
                end
                results_due.push_back(mk(K_ZERO_DONE, 0, 0, 0, 0, 1));
            end
            default: begin
            end
        endcase
    endtask

    // Predict on input beats, compare on output beats.
    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            for (int i = 0; i < TimedSlots; i++) begin
                tm_act[i] = 0; tm_anchor[i] = 0; tm_rep[i] = 0;
            end
            for (int i = 0; i < AsapSlots; i++) as_act[i] = 0;
            for (int i = 0; i < AlapSlots; i++) al_act[i] = 0;
            handle_next = 1;
            results_due.delete();
            o_errors = 0;
            o_fires = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result beat with nothing expected, kind %0d", i_kind);
                    o_errors++;
                end else begin
                    e = results_due.pop_front();
                    if (i_kind != e.kind) begin
                        $error("kind: expected %0d, got %0d", e.kind, i_kind); o_errors++;
                    end
                    if (i_slot_handle != e.handle) begin
                        $error("slot_handle: expected %0h, got %0h", e.handle, i_slot_handle);
                        o_errors++;
                    end
                    if (i_ok != e.ok) begin
                        $error("ok: expected %0d, got %0d", e.ok, i_ok); o_errors++;
                    end
                    if (i_cancel_count != e.count) begin
                        $error("cancel_count: expected %0d, got %0d", e.count, i_cancel_count);
                        o_errors++;
                    end
                    if (i_fire_count != e.fire_at) begin
                        $error("fire_count: expected %0h, got %0h", e.fire_at, i_fire_count);
                        o_errors++;
                    end
                    if (i_last != e.last) begin
                        $error("last: expected %0d, got %0d", e.last, i_last); o_errors++;
                    end
                    if (e.kind == K_TIMED_FIRE) o_fires++;
                end
            end
            if (i_valid && !i_stall_in)
                schedule_beat(t_opcode'(i_opcode), i_delay_ns, i_recurring, i_name_tag,
                              i_cancel_handle, i_now_count);
        end
        o_pending = results_due.size();
    end

endmodule

@@ tb/sv/multi_slot_tick_timer_scheduler_tb.sv @@
`timescale 1ns / 1ps
module multi_slot_tick_timer_scheduler_tb;
    import mstts_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_opcode;
    logic [63:0] i_delay_ns;
    logic        i_recurring;
    logic [7:0]  i_name_tag;
    logic [31:0] i_cancel_handle;
    logic [31:0] i_now_count;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_kind;
    logic [31:0] o_slot_handle;
    logic        o_ok;
    logic [4:0]  o_cancel_count;
    logic [31:0] o_fire_count;
    logic        o_last;

    int errors;
    int pending;
    int fires;
    int cycles;
    int beats_sent;
    bit calm;
    bit hold_long;
    logic [31:0] tick_now;

    multi_slot_tick_timer_scheduler u_dut (.*);

    multi_slot_tick_timer_scheduler_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_opcode(i_opcode), .i_delay_ns(i_delay_ns), .i_recurring(i_recurring),
        .i_name_tag(i_name_tag), .i_cancel_handle(i_cancel_handle),
        .i_now_count(i_now_count), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_kind(o_kind), .i_slot_handle(o_slot_handle), .i_ok(o_ok),
        .i_cancel_count(o_cancel_count), .i_fire_count(o_fire_count), .i_last(o_last),
        .o_errors(errors), .o_pending(pending), .o_fires(fires)
    );

    // Clock.
    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("multi_slot_tick_timer_scheduler test failed");
            $finish;
        end
    end

    // Receiver stalls: rare random stalls, none while calm, a long hold on request.
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                i_stall <= 1'b1;
                for (n = 0; n < 300; n++) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_long = 0;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < 6);
            end
        end
    end

    // Sends one beat and waits for it to be taken.
    task automatic send(t_opcode op, logic [63:0] ns, logic rec, logic [7:0] tag,
                        logic [31:0] ch);
        while (!calm && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        if (op == OP_TICK) tick_now = tick_now + $urandom_range(20000);
        i_valid <= 1'b1;
        i_opcode <= op;
        i_delay_ns <= ns;
        i_recurring <= rec;
        i_name_tag <= tag;
        i_cancel_handle <= ch;
        i_now_count <= (op == OP_TICK) ? tick_now : $urandom;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic drain_all();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_delay();
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(250));
            default: return 64'($urandom_range(600000));
        endcase
    endfunction

    function automatic t_opcode pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 25) return OP_ARM_TIMED;
        if (r < 37) return OP_ARM_ASAP;
        if (r < 45) return OP_ARM_ALAP;
        if (r < 55) return OP_CANCEL_HANDLE;
        if (r < 62) return OP_CANCEL_NAME;
        if (r < 94) return OP_TICK;
        if (r < 97) return OP_ZERO;
        return OP_NONE;
    endfunction

    initial begin
        t_opcode op;
        cycles = 0;
        beats_sent = 0;
        calm = 0;
        hold_long = 0;
        tick_now = 32'hFFFF_F000;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = OP_NONE;
        i_delay_ns = 0;
        i_recurring = 0;
        i_name_tag = 0;
        i_cancel_handle = 0;
        i_now_count = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: clamps, each table, name retire, zero cancels, unknown opcode.
        send(OP_ARM_TIMED, 64'd0, 1'b0, 8'd0, 0);
        send(OP_ARM_TIMED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'hFF, 0);
        send(OP_ARM_TIMED, 64'd150, 1'b1, 8'd1, 0);
        send(OP_ARM_ASAP, 0, 1'b0, 8'd1, 0);
        send(OP_ARM_ALAP, 0, 1'b0, 8'd2, 0);
        send(OP_CANCEL_HANDLE, 0, 1'b0, 8'd0, 32'd0);
        send(OP_CANCEL_HANDLE, 0, 1'b0, 8'd0, 32'hFFFF_FFFF);
        send(OP_CANCEL_NAME, 0, 1'b0, 8'd0, 0);
        send(OP_NONE, 64'd5, 1'b1, 8'd3, 32'd7);
        send(OP_TICK, 0, 1'b0, 8'd0, 0);
        send(OP_TICK, 0, 1'b0, 8'd0, 0);
        send(OP_ZERO, 0, 1'b0, 8'd0, 0);
        send(OP_TICK, 0, 1'b0, 8'd0, 0);
        send(OP_CANCEL_NAME, 0, 1'b0, 8'hFF, 0);
        // Overfill the ASAP and ALAP tables so an arm fails.
        for (int i = 0; i < 9; i++) send(OP_ARM_ASAP, 0, 1'b0, 8'd0, 0);
        for (int i = 0; i < 5; i++) send(OP_ARM_ALAP, 0, 1'b0, 8'd0, 0);
        drain_all();
        for (int i = 0; i < 17; i++) send(OP_ARM_TIMED, 64'd100, 1'b1, 8'd9, 0);
        send(OP_ARM_TIMED, 64'd100, 1'b0, 8'd0, 0);
        send(OP_TICK, 0, 1'b0, 8'd0, 0);

        // Long receiver hold while the sender keeps offering beats.
        hold_long = 1;
        for (int i = 0; i < 20; i++) send(pick_op(), pick_delay(), $urandom_range(1),
                                          8'($urandom_range(7)), $urandom_range(40));
        drain_all();

        // Random traffic, with a calm stretch in the middle.
        for (int i = 0; i < 95; i++) begin
            calm = (i >= 35 && i < 60);
            op = pick_op();
            send(op, pick_delay(), $urandom_range(1),
                 ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(7)),
                 ($urandom_range(9) == 0) ? $urandom : $urandom_range(beats_sent + 2));
        end
        calm = 0;
        drain_all();
        repeat (100) @(posedge i_clk);

        $display("Sent %0d beats across all opcodes, table overflow and a long output hold;",
                 beats_sent);
        $display("%0d timed fires were checked.", fires);
        if (errors == 0 && pending == 0) begin
            $display("multi_slot_tick_timer_scheduler test passed");
        end else begin
            $display("multi_slot_tick_timer_scheduler test failed");
        end
        $finish;
    end

endmodule
